@@ hw/rtl/smau_pkg.sv @@
// shared types, opcodes and widths for the simd multimedia alu unit
package smau_pkg;

    localparam int IN_W   = 288;
    localparam int OUT_W  = 144;
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    localparam logic [5:0] FN_PLZCW = 6'h04;
    localparam logic [5:0] FN_MMI0  = 6'h08;
    localparam logic [5:0] FN_MMI2  = 6'h09;
    localparam logic [5:0] FN_MFHI1 = 6'h10;
    localparam logic [5:0] FN_MFLO1 = 6'h12;
    localparam logic [5:0] FN_MULT1 = 6'h18;
    localparam logic [5:0] FN_DIVU1 = 6'h1B;
    localparam logic [5:0] FN_MMI3  = 6'h29;

    localparam logic [4:0] SUB_PSUBB  = 5'h09;
    localparam logic [4:0] SUB_PCPY   = 5'h0E;
    localparam logic [4:0] SUB_PANDOR = 5'h12;
    localparam logic [4:0] SUB_PNOR   = 5'h13;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_DIVZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MULT   = 2'd1,
        KIND_DIV    = 2'd2
    } t_op_kind;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_EXEC   = 3'd1,
        S_MUL    = 3'd2,
        S_MUL_WB = 3'd3,
        S_DIV    = 3'd4,
        S_DIV_WB = 3'd5,
        S_WRITE  = 3'd6
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic mul_prod;
        logic mul_wb;
        logic div_step;
        logic div_wb;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op_kind kind;
        logic     div_last;
        logic     out_busy;
    } t_dp_stat;

endpackage

@@ hw/rtl/simd_multimedia_alu_unit.sv @@
// top level of the simd multimedia alu unit: controller plus datapath
// Executes one 128-bit multimedia instruction per input word and returns one
// result word. Logic, copy, byte-subtract, plzcw and mfhi1/mflo1 pass through
// the exec and write states before the next word can be accepted; mult1 adds
// states for one registered 32x32 signed multiply plus lo1/hi1 write back;
// divu1 adds the radix-2 restoring divider that produces one quotient bit per
// cycle over 32 steps, and skips the divider with a zero divisor. A finished
// result sits in an output register so the next word is accepted while it
// waits to be taken; a result that finds the previous one still waiting holds
// until that one is taken. An unknown opcode or a zero divisor returns a
// status code with no write enables and leaves lo1/hi1 unchanged.
module simd_multimedia_alu_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction, rs_low, rs_high, rt_low, rt_high
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dest_index, write_low, write_high, result_low, result_high, status, zero pad
    output logic [143:0] m_axis_tdata
);
    import smau_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    smau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    smau_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (s_axis_tdata),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

@@ hw/rtl/smau_ctrl.sv @@
// controller state machine sequencing decode, multiply, divide and result load
module smau_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  smau_pkg::t_dp_stat i_stat,
    output smau_pkg::t_dp_cmd  o_cmd
);
    import smau_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.kind)
                    KIND_MULT: n_state = S_MUL;
                    KIND_DIV:  n_state = S_DIV;
                    default:   n_state = S_WRITE;
                endcase
            end
            S_MUL: begin
                o_cmd.mul_prod = 1'b1;
                n_state        = S_MUL_WB;
            end
            S_MUL_WB: begin
                o_cmd.mul_wb = 1'b1;
                n_state      = S_WRITE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DIV_WB;
                end
            end
            S_DIV_WB: begin
                o_cmd.div_wb = 1'b1;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/smau_dp.sv @@
// datapath: operand registers, decode, simd ops, multiplier, radix-2 divider, lo1/hi1
module smau_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  smau_pkg::t_dp_cmd           i_cmd,
    input  logic [smau_pkg::IN_W-1:0]   i_in_data,
    output smau_pkg::t_dp_stat          o_stat,
    output logic                        o_out_valid,
    output logic [smau_pkg::OUT_W-1:0]  o_out_data,
    input  logic                        i_out_ready
);
    import smau_pkg::*;

    function automatic logic [4:0] lead_same(input logic [HALF_W-1:0] w);
        logic [HALF_W-2:0] x;
        logic [4:0]        n;
        logic              found;
        x     = w[HALF_W-2:0] ^ {(HALF_W-1){w[HALF_W-1]}};
        n     = 5'd31;
        found = 1'b0;
        for (int j = HALF_W - 2; j >= 0; j--) begin
            if (!found && x[j]) begin
                found = 1'b1;
                n     = 5'(HALF_W - 2 - j);
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] sub_bytes(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_W / 8; k++) begin
            r[k*8 +: 8] = a[k*8 +: 8] - b[k*8 +: 8];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{HALF_W{v[HALF_W-1]}}, v};
    endfunction

    logic [31:0]       r_instr;
    logic [WORD_W-1:0] r_rsl;
    logic [WORD_W-1:0] r_rsh;
    logic [WORD_W-1:0] r_rtl;
    logic [WORD_W-1:0] r_rth;

    logic [HALF_W-1:0] r_lo;
    logic [HALF_W-1:0] r_hi;

    logic              r_wl;
    logic              r_wh;
    logic [WORD_W-1:0] r_rl;
    logic [WORD_W-1:0] r_rh;
    t_status           r_st;

    logic [WORD_W-1:0] r_prod;

    logic [HALF_W-1:0] r_quo;
    logic [HALF_W-1:0] r_rem;
    logic [4:0]        r_cnt;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [5:0]        w_funct;
    logic [4:0]        w_sub;
    t_op_kind          d_kind;
    logic              d_wl;
    logic              d_wh;
    logic [WORD_W-1:0] d_rl;
    logic [WORD_W-1:0] d_rh;
    t_status           d_st;

    logic [HALF_W:0]   w_trial;
    logic              w_fits;

    assign w_funct = r_instr[5:0];
    assign w_sub   = r_instr[10:6];

    always_comb begin
        d_kind = KIND_SIMPLE;
        d_wl   = 1'b0;
        d_wh   = 1'b0;
        d_rl   = '0;
        d_rh   = '0;
        d_st   = STAT_OK;
        case (w_funct)
            FN_PLZCW: begin
                d_rl = {27'd0, lead_same(r_rsl[63:32]), 27'd0, lead_same(r_rsl[31:0])};
                d_wl = 1'b1;
            end
            FN_MMI0: begin
                if (w_sub == SUB_PSUBB) begin
                    d_rl = sub_bytes(r_rsl, r_rtl);
                    d_rh = sub_bytes(r_rsh, r_rth);
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else begin
                    d_st = STAT_UNKNOWN;
                end
            end
            FN_MMI2: begin
                if (w_sub == SUB_PCPY) begin
                    d_rl = r_rtl;
                    d_rh = r_rsl;
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else if (w_sub == SUB_PANDOR) begin
                    d_rl = r_rsl & r_rtl;
                    d_rh = r_rsh & r_rth;
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else begin
                    d_st = STAT_UNKNOWN;
                end
            end
            FN_MMI3: begin
                if (w_sub == SUB_PCPY) begin
                    d_rl = r_rth;
                    d_rh = r_rsh;
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else if (w_sub == SUB_PANDOR) begin
                    d_rl = r_rsl | r_rtl;
                    d_rh = r_rsh | r_rth;
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else if (w_sub == SUB_PNOR) begin
                    d_rl = ~(r_rsl | r_rtl);
                    d_rh = ~(r_rsh | r_rth);
                    d_wl = 1'b1;
                    d_wh = 1'b1;
                end else begin
                    d_st = STAT_UNKNOWN;
                end
            end
            FN_MFHI1: begin
                d_rl = sext32(r_hi);
                d_wl = 1'b1;
            end
            FN_MFLO1: begin
                d_rl = sext32(r_lo);
                d_wl = 1'b1;
            end
            FN_MULT1: begin
                d_kind = KIND_MULT;
                d_wl   = 1'b1;
            end
            FN_DIVU1: begin
                if (r_rtl[HALF_W-1:0] == '0) begin
                    d_st = STAT_DIVZERO;
                end else begin
                    d_kind = KIND_DIV;
                end
            end
            default: begin
                d_st = STAT_UNKNOWN;
            end
        endcase
    end

    // restoring divide, one quotient bit per step
    assign w_trial = {r_rem, r_quo[HALF_W-1]} - {1'b0, r_rtl[HALF_W-1:0]};
    assign w_fits  = !w_trial[HALF_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_instr <= i_in_data[31:0];
            r_rsl   <= i_in_data[95:32];
            r_rsh   <= i_in_data[159:96];
            r_rtl   <= i_in_data[223:160];
            r_rth   <= i_in_data[287:224];
        end
        if (i_cmd.exec) begin
            r_wl  <= d_wl;
            r_wh  <= d_wh;
            r_rl  <= d_rl;
            r_rh  <= d_rh;
            r_st  <= d_st;
            r_quo <= r_rsl[HALF_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.mul_prod) begin
            r_prod <= 64'($signed(r_rsl[HALF_W-1:0]) * $signed(r_rtl[HALF_W-1:0]));
        end
        if (i_cmd.mul_wb) begin
            r_rl <= sext32(r_prod[HALF_W-1:0]);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[HALF_W-2:0], w_fits};
            r_rem <= w_fits ? w_trial[HALF_W-1:0] : {r_rem[HALF_W-2:0], r_quo[HALF_W-1]};
        end
        if (i_cmd.out_load) begin
            r_out_data <= {7'd0, r_st, r_rh, r_rl, r_wh, r_wl, r_instr[15:11]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= '0;
            r_hi        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mul_wb) begin
                r_lo <= r_prod[HALF_W-1:0];
                r_hi <= r_prod[WORD_W-1:HALF_W];
            end
            if (i_cmd.div_wb) begin
                r_lo <= r_quo;
                r_hi <= r_rem;
            end
            if (i_cmd.exec) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.kind     = d_kind;
        o_stat.div_last = (r_cnt == 5'd31);
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
